[hw/rtl/kim_pkg.sv]
// Shared types and constants for the key-to-ID mapper.
package kim_pkg;

  localparam int ENTRIES  = 64;
  localparam int KEY_BITS = 64;
  localparam int ID_BITS  = 16;

  localparam int KEY_IN_W = 64;
  localparam int ID_IN_W  = 16;
  localparam int STATUS_W = 2;

  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int MAX_ID      = (1 << ID_BITS) - 1;
  localparam int MAX_NUM_IDS = MAX_ID - 1;
  // zero-ID requests fail once this many keys are bound
  localparam int ID_FULL_LIMIT = (ENTRIES < MAX_NUM_IDS) ? ENTRIES : MAX_NUM_IDS;
  // a free ID always lies within 1 .. CAND_N
  localparam int CAND_N = (ENTRIES + 1 < MAX_ID) ? ENTRIES + 1 : MAX_ID;

  typedef enum logic [0:0] {
    OP_MAP   = 1'b0,
    OP_UNMAP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_CONFLICT  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_BIND   = 2'd1,
    ACT_UNBIND = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SCAN   = 3'd1,
    S_FLUSH  = 3'd2,
    S_DECIDE = 3'd3,
    S_SEARCH = 3'd4,
    S_FINISH = 3'd5
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic search;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic need_search;
    logic free_hit;
    logic out_busy;
  } stat_t;

endpackage

[hw/rtl/kim_ctrl.sv]
// Sequencing state machine for the key-to-ID mapper.
module kim_ctrl
  import kim_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = stat.need_search ? S_SEARCH : S_FINISH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.free_hit) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/kim_datapath.sv]
// Table storage, scan accumulators, free-ID search and result register.
module kim_datapath
  import kim_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [0:0]          operation,
  input  logic [KEY_IN_W-1:0] key,
  input  logic [ID_IN_W-1:0]  requested_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ID_IN_W-1:0]  assigned_id
);

  logic [KEY_BITS-1:0] mem_key [ENTRIES];
  logic [ID_BITS-1:0]  mem_id  [ENTRIES];
  logic [ENTRIES-1:0]  entry_valid;

  logic                req_unmap;
  logic [KEY_BITS-1:0] req_key;
  logic [ID_BITS-1:0]  req_id;

  logic [IDX_W-1:0]    scan_addr;
  logic                rd_en;
  logic                rd_v;
  logic [IDX_W-1:0]    rd_idx;
  logic [KEY_BITS-1:0] rd_key;
  logic [ID_BITS-1:0]  rd_id;

  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [ID_BITS-1:0]  hit_id;
  logic                id_used;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic [CNT_W-1:0]    count;
  logic [CAND_N-1:0]   used;
  logic [CAND_N-1:0]   used_next;
  logic [ID_BITS-1:0]  cand;

  status_t             res_status;
  logic [ID_BITS-1:0]  res_id;
  act_t                act;
  logic                need_search;

  status_t             out_status;
  logic [ID_BITS-1:0]  out_id;

  // table read, one entry per cycle during the scan
  always_ff @(posedge clk) begin
    rd_key <= mem_key[scan_addr];
    rd_id  <= mem_id[scan_addr];
    rd_v   <= entry_valid[scan_addr];
    rd_idx <= scan_addr;
    if (cmd.finish && act == ACT_BIND) begin
      mem_key[free_idx] <= req_key;
      mem_id[free_idx]  <= res_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_en       <= 1'b0;
    end else begin
      rd_en <= cmd.scan;
      if (cmd.finish && act == ACT_BIND) begin
        entry_valid[free_idx] <= 1'b1;
      end else if (cmd.finish && act == ACT_UNBIND) begin
        entry_valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_comb begin
    used_next = used;
    for (int k = 0; k < CAND_N; k++) begin
      if (rd_en && rd_v && rd_id == ID_BITS'(k + 1)) begin
        used_next[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_unmap  <= (operation == OP_UNMAP);
      req_key    <= key[KEY_BITS-1:0];
      req_id     <= requested_id[ID_BITS-1:0];
      scan_addr  <= '0;
      hit        <= 1'b0;
      id_used    <= 1'b0;
      free_found <= 1'b0;
      count      <= '0;
      used       <= '0;
      cand       <= ID_BITS'(1);
    end else begin
      if (cmd.scan) begin
        scan_addr <= scan_addr + IDX_W'(1);
      end
      if (rd_en) begin
        used <= used_next;
        if (rd_v) begin
          count <= count + CNT_W'(1);
          if (!hit && rd_key == req_key) begin
            hit     <= 1'b1;
            hit_idx <= rd_idx;
            hit_id  <= rd_id;
          end
          if (rd_id == req_id) begin
            id_used <= 1'b1;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
      if (cmd.search && used[0]) begin
        used <= used >> 1;
        cand <= cand + ID_BITS'(1);
      end
    end
  end

  always_comb begin
    res_status  = ST_OK;
    res_id      = '0;
    act         = ACT_NONE;
    need_search = 1'b0;
    if (req_unmap) begin
      if (hit) begin
        act = ACT_UNBIND;
      end else begin
        res_status = ST_NOT_FOUND;
      end
    end else if (req_id != '0) begin
      if (hit) begin
        if (hit_id == req_id) begin
          res_id = req_id;
        end else begin
          res_status = ST_CONFLICT;
        end
      end else if (id_used) begin
        res_status = ST_CONFLICT;
      end else if (!free_found) begin
        res_status = ST_FULL;
      end else begin
        res_id = req_id;
        act    = ACT_BIND;
      end
    end else if (hit) begin
      res_id = hit_id;
    end else if (count >= CNT_W'(ID_FULL_LIMIT) || !free_found) begin
      res_status = ST_FULL;
    end else begin
      res_id      = cand;
      act         = ACT_BIND;
      need_search = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= res_status;
      out_id     <= res_id;
    end
  end

  assign status      = out_status;
  assign assigned_id = ID_IN_W'(out_id);

  assign stat.scan_last   = (scan_addr == IDX_W'(ENTRIES - 1));
  assign stat.need_search = need_search;
  assign stat.free_hit    = !used[0];
  assign stat.out_busy    = out_valid && !out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && !out_ready))
    else $error("result register overwritten while held");

  a_bind_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && act == ACT_BIND) |-> !entry_valid[free_idx])
    else $error("bind into an occupied slot");

  a_bind_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && act == ACT_BIND) |=> entry_valid[$past(free_idx)])
    else $error("bound slot not marked valid");

  a_cand_range: assert property (@(posedge clk) disable iff (rst)
    cmd.search |-> (cand != '0 && cand <= ID_BITS'(CAND_N)))
    else $error("free-ID candidate out of range");

  a_unbind_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && act == ACT_UNBIND) |=> !entry_valid[$past(hit_idx)])
    else $error("unmapped slot still valid");

endmodule

[hw/rtl/key_to_id_mapper.sv]
// Key-to-ID mapper top level: binds keys to IDs, lowest free ID first.
//
// Input channel: in_valid/in_ready with operation, key and requested_id.
// Output channel: out_valid/out_ready with status and assigned_id, one
// result beat for every input beat, in order.
// One request is handled at a time. in_ready is high only while the
// sequencer is idle. A request is accepted, the table is scanned through
// its single read port, the last read is flushed (S_FLUSH) and the result
// decided (S_DECIDE), and the finish step writes back and loads the
// result. A zero-ID request for a new key adds a search step that passes
// each used ID below the lowest free one.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls, the following request halts at
// its write-back step until the register is taken.
// Reset clears every valid bit at once, leaving the table empty; no
// clearing pass is needed.
module key_to_id_mapper
  import kim_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [0:0]          operation,
  input  logic [KEY_IN_W-1:0] key,
  input  logic [ID_IN_W-1:0]  requested_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ID_IN_W-1:0]  assigned_id
);

  cmd_t  cmd;
  stat_t stat;

  kim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kim_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .key          (key),
    .requested_id (requested_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .assigned_id  (assigned_id)
  );

endmodule
